// ===== hdl/bse_pkg.sv =====
// bse_pkg: shared constants, function codes and the queued word type
// of the bitmap set engine; no dependencies
`default_nettype none

package bse_pkg;

    // fixed word geometry
    localparam int WORD_BITS     = 64;
    localparam int SEL_W         = 6;
    localparam int MAX_WORDS_DEF = 1024;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 16;
    localparam int WIDX_W  = 10;
    localparam int COUNT_W = 11;
    // wide enough for any word count up to the largest store
    localparam int CMP_W   = 17;

    // apb register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // function codes
    localparam logic [FUNC_W-1:0] FN_CLEAR_ALL = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET       = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TEST      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNION     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_INTERSECT = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SUBTRACT  = 3'd6;

    // one classified word waiting for the back end
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic                 err;
        logic [WIDX_W-1:0]    addr;
        logic [SEL_W-1:0]     bit_sel;
        logic [WORD_BITS-1:0] other;
        logic                 last;
        logic [CMP_W-1:0]     used;
    } bse_item_t;

endpackage

`default_nettype wire

// ===== hdl/bse_front.sv =====
// bse_front: accepts input words, range-checks them and builds queue entries
// depends on bse_pkg
`default_nettype none

module bse_front #(
    parameter int MAX_WORDS = bse_pkg::MAX_WORDS_DEF
) (
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [bse_pkg::FUNC_W-1:0]      func,
    input  wire logic [bse_pkg::ID_W-1:0]        bit_index,
    input  wire logic [bse_pkg::WIDX_W-1:0]      word_index,
    input  wire logic [bse_pkg::WORD_BITS-1:0]   other_word,
    input  wire logic                            last_word,
    input  wire logic [bse_pkg::COUNT_W-1:0]     word_count,
    input  wire logic                            q_full,
    input  wire logic                            init_busy,
    output logic                                 push,
    output bse_pkg::bse_item_t                   item
);

    logic [bse_pkg::CMP_W-1:0]  count_ext;
    logic [bse_pkg::CMP_W-1:0]  max_ext;
    logic [bse_pkg::CMP_W-1:0]  used;
    logic [bse_pkg::WIDX_W-1:0] id_word;
    logic [bse_pkg::WIDX_W-1:0] addr;
    logic                       err;

    // effective word count saturates at the store depth
    assign count_ext = bse_pkg::CMP_W'(word_count);
    assign max_ext   = bse_pkg::CMP_W'(MAX_WORDS);
    assign used      = (count_ext > max_ext) ? max_ext : count_ext;

    // word holding the id
    assign id_word = bit_index[bse_pkg::ID_W-1:bse_pkg::SEL_W];

    // pick address and range check by function class
    always_comb
    begin
        addr = word_index;
        err  = 1'b0;
        case (func) inside
            bse_pkg::FN_SET, bse_pkg::FN_CLEAR, bse_pkg::FN_TEST:
            begin
                addr = id_word;
                err  = (bse_pkg::CMP_W'(id_word) >= used);
            end
            bse_pkg::FN_UNION, bse_pkg::FN_INTERSECT, bse_pkg::FN_SUBTRACT:
            begin
                addr = word_index;
                err  = (bse_pkg::CMP_W'(word_index) >= used);
            end
            default:
            begin
                addr = word_index;
                err  = 1'b0;
            end
        endcase
    end

    // no words taken while the store is being cleared after reset
    assign in_ready = !q_full && !init_busy;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        item.func    = func;
        item.err     = err;
        item.addr    = addr;
        item.bit_sel = bit_index[bse_pkg::SEL_W-1:0];
        item.other   = other_word;
        item.last    = last_word;
        item.used    = used;
    end

endmodule

`default_nettype wire

// ===== hdl/bse_queue.sv =====
// bse_queue: short fifo of classified words between front and back
// depends on bse_pkg
`default_nettype none

module bse_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bse_pkg::bse_item_t push_item,
    input  wire logic               pop,
    output bse_pkg::bse_item_t      head,
    output logic                    empty,
    output logic                    full
);

    localparam int PTR_W = (bse_pkg::QUEUE_DEPTH > 1) ? $clog2(bse_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bse_pkg::QUEUE_DEPTH + 1);

    bse_pkg::bse_item_t entry_reg [bse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(bse_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bse_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bse_back.sv =====
// bse_back: bitmap store, read-modify-write of one word, clearing walks
// and the result register; depends on bse_pkg
`default_nettype none

module bse_back #(
    parameter int MAX_WORDS = bse_pkg::MAX_WORDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bse_pkg::bse_item_t head,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    init_busy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    bit_value,
    output logic                    index_error
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    logic [bse_pkg::WORD_BITS-1:0] mem [MAX_WORDS];
    logic [bse_pkg::WORD_BITS-1:0] rdata_reg;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [CW-1:0]            walk_reg;
    logic [CW-1:0]            walk_next;
    logic [CW-1:0]            walk_end_reg;
    logic [CW-1:0]            walk_end_next;
    bse_pkg::bse_item_t       cur_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     bit_value_reg;
    logic                     bit_value_next;
    logic                     index_error_reg;
    logic                     index_error_next;

    logic                          re;
    logic [AW-1:0]                 raddr;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [bse_pkg::WORD_BITS-1:0] wdata;
    logic [bse_pkg::CMP_W-1:0]     head_addr_ext;
    logic [bse_pkg::CMP_W-1:0]     cur_addr_ext;
    logic [bse_pkg::CMP_W-1:0]     cur_addr_inc;
    logic [bse_pkg::WORD_BITS-1:0] mask;
    logic [bse_pkg::WORD_BITS-1:0] mod_word;
    logic                          mod_en;
    logic                          tail_clear;
    logic                          out_free;
    logic [CW-1:0]                 walk_inc;

    assign head_addr_ext = bse_pkg::CMP_W'(head.addr);
    assign cur_addr_ext  = bse_pkg::CMP_W'(cur_reg.addr);
    assign cur_addr_inc  = cur_addr_ext + 1'b1;
    assign walk_inc      = walk_reg + 1'b1;
    assign out_free      = !out_valid_reg || out_ready;

    // msb-first bit select within the word
    assign mask = {1'b1, {(bse_pkg::WORD_BITS-1){1'b0}}} >> cur_reg.bit_sel;

    // modified word and whether it goes back to the store
    always_comb
    begin
        mod_word = rdata_reg;
        mod_en   = 1'b0;
        case (cur_reg.func)
            bse_pkg::FN_SET:
            begin
                mod_word = rdata_reg | mask;
                mod_en   = 1'b1;
            end
            bse_pkg::FN_CLEAR:
            begin
                mod_word = rdata_reg & ~mask;
                mod_en   = 1'b1;
            end
            bse_pkg::FN_UNION:
            begin
                mod_word = rdata_reg | cur_reg.other;
                mod_en   = 1'b1;
            end
            bse_pkg::FN_INTERSECT:
            begin
                mod_word = rdata_reg & cur_reg.other;
                mod_en   = 1'b1;
            end
            bse_pkg::FN_SUBTRACT:
            begin
                mod_word = rdata_reg & ~cur_reg.other;
                mod_en   = 1'b1;
            end
            default:
            begin
                mod_word = rdata_reg;
                mod_en   = 1'b0;
            end
        endcase
    end

    // last intersect word clears the rest of the words in use
    assign tail_clear = (cur_reg.func == bse_pkg::FN_INTERSECT) && cur_reg.last &&
                        !cur_reg.err && (cur_addr_inc < cur_reg.used);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        walk_end_next    = walk_end_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        bit_value_next   = bit_value_reg;
        index_error_next = index_error_reg;
        pop              = 1'b0;
        re               = 1'b0;
        raddr            = head_addr_ext[AW-1:0];
        we               = 1'b0;
        waddr            = walk_reg[AW-1:0];
        wdata            = '0;
        case (state_reg)
            S_INIT, S_WALK:
            begin
                we        = 1'b1;
                waddr     = walk_reg[AW-1:0];
                wdata     = '0;
                walk_next = walk_inc;
                if (walk_inc == walk_end_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    re         = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    index_error_next = cur_reg.err;
                    bit_value_next   = (cur_reg.func == bse_pkg::FN_TEST) && !cur_reg.err &&
                                       ((rdata_reg & mask) != '0);
                    we    = mod_en && !cur_reg.err;
                    waddr = cur_addr_ext[AW-1:0];
                    wdata = mod_word;
                    if (cur_reg.func == bse_pkg::FN_CLEAR_ALL)
                    begin
                        walk_next     = '0;
                        walk_end_next = CW'(MAX_WORDS);
                        state_next    = S_WALK;
                    end
                    else if (tail_clear)
                    begin
                        walk_next     = CW'(cur_addr_inc);
                        walk_end_next = CW'(cur_reg.used);
                        state_next    = S_WALK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            walk_reg      <= '0;
            walk_end_reg  <= CW'(MAX_WORDS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            walk_end_reg  <= walk_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload and current word
    always_ff @(posedge clk)
    begin
        bit_value_reg   <= bit_value_next;
        index_error_reg <= index_error_next;
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    // bitmap store with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign init_busy   = (state_reg == S_INIT);
    assign out_valid   = out_valid_reg;
    assign bit_value   = bit_value_reg;
    assign index_error = index_error_reg;

endmodule

`default_nettype wire

// ===== hdl/bitmap_set_engine.sv =====
// bitmap_set_engine: top level with apb word_count register, front, queue, back
// depends on bse_pkg, bse_front, bse_queue, bse_back
// flow: an accepted word is queued, popped with its store read in idle, then
// executed with its result registered once the output is free; the next word
// is popped only after that (memory read then modify-write); clear all walks
// all MAX_WORDS words, a last intersect word walks the later words in use
// reset: store cleared by walking all MAX_WORDS words, no words taken meanwhile
`default_nettype none

module bitmap_set_engine #(
    parameter int MAX_WORDS = bse_pkg::MAX_WORDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bse_pkg::FUNC_W-1:0]        func,
    input  wire logic [bse_pkg::ID_W-1:0]          bit_index,
    input  wire logic [bse_pkg::WIDX_W-1:0]        word_index,
    input  wire logic [bse_pkg::WORD_BITS-1:0]     other_word,
    input  wire logic                              last_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   bit_value,
    output logic                                   index_error,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bse_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [bse_pkg::PDATA_W-1:0]       pwdata,
    output logic [bse_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);

    logic [bse_pkg::COUNT_W-1:0] word_count_reg;
    logic [bse_pkg::COUNT_W-1:0] word_count_next;
    logic                        cfg_write;
    logic                        q_full;
    logic                        q_empty;
    logic                        push;
    logic                        pop;
    logic                        init_busy;
    bse_pkg::bse_item_t          push_item;
    bse_pkg::bse_item_t          head;

    // apb register: word_count is the only register, every address maps to it
    assign pready          = 1'b1;
    assign cfg_write       = psel && penable && pwrite && pready;
    assign word_count_next = cfg_write ? pwdata[bse_pkg::COUNT_W-1:0] : word_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= bse_pkg::COUNT_W'(1024);
        end
        else
        begin
            word_count_reg <= word_count_next;
        end
    end

    // read data, every address returns the one register
    always_comb
    begin
        prdata = bse_pkg::PDATA_W'(word_count_reg);
        if (paddr != '0)
        begin
            prdata = bse_pkg::PDATA_W'(word_count_reg);
        end
    end

    // classify incoming words
    bse_front #(
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .bit_index  (bit_index),
        .word_index (word_index),
        .other_word (other_word),
        .last_word  (last_word),
        .word_count (word_count_reg),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .push       (push),
        .item       (push_item)
    );

    // decoupling queue
    bse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // store and execution
    bse_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_value   (bit_value),
        .index_error (index_error)
    );

endmodule

`default_nettype wire
